// ===== rtl/core/mlps_pkg.sv =====
// Shared types, sizes and the sigmoid lookup table for the MLP sigmoid block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mlps_pkg;

  localparam int IN_SIZE  = 256;
  localparam int HIDDEN1  = 16;
  localparam int HIDDEN2  = 16;
  localparam int OUT_SIZE = 16;

  localparam int W_L1_BASE = IN_SIZE * HIDDEN1;
  localparam int W_L2_BASE = W_L1_BASE + HIDDEN1 * HIDDEN2;
  localparam int W_TOTAL   = W_L2_BASE + HIDDEN2 * OUT_SIZE;
  localparam int B_TOTAL   = HIDDEN1 + HIDDEN2 + OUT_SIZE;
  localparam int H_TOTAL   = HIDDEN1 + HIDDEN2;

  localparam int WA_W  = $clog2(W_TOTAL);
  localparam int BA_W  = $clog2(B_TOTAL);
  localparam int HA_W  = $clog2(H_TOTAL);
  localparam int POS_W = $clog2(IN_SIZE + 1);

  localparam int MAX_N  = (HIDDEN1 > HIDDEN2) ?
                          ((HIDDEN1 > OUT_SIZE) ? HIDDEN1 : OUT_SIZE) :
                          ((HIDDEN2 > OUT_SIZE) ? HIDDEN2 : OUT_SIZE);
  localparam int NEUR_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CNT_W  = $clog2(MAX_N + 3);

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);

  localparam int SIG_ENTRIES = 1024;
  localparam logic [63:0] EXP_STEP = 64'd4162825044;

  localparam logic [1:0] LAYER_H1  = 2'd0;
  localparam logic [1:0] LAYER_H2  = 2'd1;
  localparam logic [1:0] LAYER_OUT = 2'd2;

  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_BIAS   = 2'd1;
  localparam logic [1:0] KIND_PIXEL  = 2'd2;

  typedef enum logic [1:0] {
    OP_WLOAD,
    OP_BLOAD,
    OP_PIXEL
  } mlps_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DOT,
    S_ACT
  } mlps_state_e;

  typedef struct packed {
    mlps_op_e          op;
    logic [WA_W-1:0]   addr;
    logic [15:0]       data;
    logic              mac;
    logic              last;
  } mlps_req_t;

  typedef logic [15:0] sig_tbl_t [SIG_ENTRIES];

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_tbl_t build_sig();
    logic [63:0] pw [513];
    logic [63:0] d;
    logic [63:0] n;
    logic [63:0] v;
    sig_tbl_t    tbl;
    pw[0] = 64'h1_0000_0000;
    for (int m = 1; m <= 512; m++) begin
      pw[m] = (pw[m-1] * EXP_STEP + 64'h8000_0000) >> 32;
    end
    for (int m = 0; m < SIG_ENTRIES; m++) begin
      if (m >= 512) begin
        d = 64'h1_0000_0000 + pw[m-512];
        n = (64'd1 << 49) + d;
      end else begin
        d = 64'h1_0000_0000 + pw[512-m];
        n = (pw[512-m] << 17) + d;
      end
      v = udiv64(n, d << 1);
      if (v > 64'd65535) v = 64'd65535;
      tbl[m] = v[15:0];
    end
    return tbl;
  endfunction

  localparam sig_tbl_t SIG_TABLE = build_sig();

endpackage
`default_nettype wire

// ===== rtl/core/mlps_queue.sv =====
// Short request queue between the front and back parts.
// Depends on mlps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlps_queue
  import mlps_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire mlps_req_t push_data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           empty_o,
  output mlps_req_t      pop_data_o
);

  mlps_req_t         mem_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == (QPTR_W+1)'(Q_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ((wr_q == QPTR_W'(Q_DEPTH-1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop  ? ((rd_q == QPTR_W'(Q_DEPTH-1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mlps_front.sv =====
// Input side: accepts items, drops ignored ones, tracks pixel position.
// Depends on mlps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlps_front
  import mlps_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [12:0] index_i,
  input  wire logic [15:0] value_i,
  input  wire logic [7:0]  pixel_i,
  input  wire logic        last_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output mlps_req_t        req_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             take, keep, in_img;

  assign in_ready_o = ~q_full_i;
  assign take       = in_valid_i & in_ready_o;
  assign in_img     = (pos_q < POS_W'(IN_SIZE));

  always_comb begin
    req_o      = '0;
    keep       = 1'b0;
    pos_d      = pos_q;
    req_o.last = last_i;
    case (kind_i)
      KIND_WEIGHT: begin
        req_o.op   = OP_WLOAD;
        req_o.addr = WA_W'(index_i);
        req_o.data = value_i;
        keep       = (32'(index_i) < W_TOTAL);
      end
      KIND_BIAS: begin
        req_o.op   = OP_BLOAD;
        req_o.addr = WA_W'(index_i);
        req_o.data = value_i;
        keep       = (32'(index_i) < B_TOTAL);
      end
      KIND_PIXEL: begin
        req_o.op   = OP_PIXEL;
        req_o.addr = WA_W'(WA_W'(pos_q) * WA_W'(HIDDEN1));
        req_o.data = {pixel_i, pixel_i};
        req_o.mac  = in_img;
        keep       = in_img | last_i;
        if (take) begin
          if (last_i) pos_d = '0;
          else if (in_img) pos_d = pos_q + 1'b1;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = take & keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mlps_back.sv =====
// Execution side: weight, bias and hidden stores, shared MAC pipeline,
// sigmoid lookup and output register. Depends on mlps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlps_back
  import mlps_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_empty_i,
  input  wire mlps_req_t  q_req_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      neuron_o,
  output logic [15:0]     activation_out_o,
  output logic            last_out_o
);

  function automatic logic signed [39:0] sat_add(input logic signed [39:0] a,
                                                 input logic signed [39:0] b);
    logic signed [40:0] s;
    s = {a[39], a} + {b[39], b};
    if (s[40] != s[39]) return s[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
    return s[39:0];
  endfunction

  logic [15:0] wmem [W_TOTAL];
  logic [15:0] bmem [B_TOTAL];
  logic [15:0] hmem [H_TOTAL];

  mlps_state_e       state_q, state_d;
  logic [1:0]        layer_q, layer_d;
  logic [NEUR_W-1:0] i_q, i_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [1:0]        step_q, step_d;
  logic [15:0]       px_q, px_d;
  logic [WA_W-1:0]   base_q, base_d;
  logic              last_q, last_d;

  logic signed [39:0] acc_q [HIDDEN1];
  logic signed [39:0] sum_q;
  logic               acc_clr, sum_clr;

  logic [WA_W-1:0]  w_raddr;
  logic [BA_W-1:0]  b_raddr;
  logic [HA_W-1:0]  h_raddr, h_waddr;
  logic             w_ren, h_wen;
  logic [15:0]      w_rd_q, b_rd_q, h_rd_q;

  logic              b_vld_q, c_vld_q;
  logic [CNT_W-1:0]  b_idx_q, c_idx_q;
  logic signed [32:0] prod_q;
  logic [CNT_W-1:0]  n_lim;
  logic              iss;

  logic [9:0]         idx_q, idx_d;
  logic [15:0]        rom_q;
  logic signed [39:0] act_src, z;
  logic signed [40:0] sh;

  logic        out_vld_q, out_vld_d, out_load;
  logic [3:0]  out_neur_q;
  logic [15:0] out_act_q;
  logic        out_last_q;

  assign n_lim = (state_q == S_MAC || layer_q == LAYER_H2) ? CNT_W'(HIDDEN1) :
                                                             CNT_W'(HIDDEN2);
  assign iss   = (state_q == S_MAC || state_q == S_DOT) && (cnt_q < n_lim);
  assign w_ren = iss;

  always_comb begin
    w_raddr = '0;
    h_raddr = '0;
    b_raddr = '0;
    h_waddr = '0;
    if (state_q == S_MAC) begin
      w_raddr = base_q + WA_W'(cnt_q);
    end else if (layer_q == LAYER_H2) begin
      w_raddr = WA_W'(W_L1_BASE) + WA_W'(cnt_q) * WA_W'(HIDDEN2) + WA_W'(i_q);
      h_raddr = HA_W'(cnt_q);
    end else begin
      w_raddr = WA_W'(W_L2_BASE) + WA_W'(cnt_q) * WA_W'(OUT_SIZE) + WA_W'(i_q);
      h_raddr = HA_W'(HIDDEN1) + HA_W'(cnt_q);
    end
    case (layer_q)
      LAYER_H1: begin
        b_raddr = BA_W'(i_q);
        h_waddr = HA_W'(i_q);
      end
      LAYER_H2: begin
        b_raddr = BA_W'(HIDDEN1) + BA_W'(i_q);
        h_waddr = HA_W'(HIDDEN1) + HA_W'(i_q);
      end
      default: begin
        b_raddr = BA_W'(HIDDEN1 + HIDDEN2) + BA_W'(i_q);
        h_waddr = '0;
      end
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && !q_empty_i && q_req_i.op == OP_WLOAD) begin
      wmem[q_req_i.addr] <= q_req_i.data;
    end
    if (w_ren) begin
      w_rd_q <= wmem[w_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && !q_empty_i && q_req_i.op == OP_BLOAD) begin
      bmem[q_req_i.addr[BA_W-1:0]] <= q_req_i.data;
    end
    b_rd_q <= bmem[b_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (h_wen) begin
      hmem[h_waddr] <= rom_q;
    end
    if (w_ren && state_q == S_DOT) begin
      h_rd_q <= hmem[h_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    rom_q <= SIG_TABLE[idx_q];
  end

  // MAC pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      b_vld_q <= iss;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_idx_q <= cnt_q;
    c_idx_q <= b_idx_q;
    prod_q  <= $signed({1'b0, (state_q == S_MAC) ? px_q : h_rd_q}) * $signed(w_rd_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HIDDEN1; k++) acc_q[k] <= '0;
    end else if (acc_clr) begin
      for (int k = 0; k < HIDDEN1; k++) acc_q[k] <= '0;
    end else if (c_vld_q && state_q == S_MAC) begin
      acc_q[c_idx_q[NEUR_W-1:0]] <= sat_add(acc_q[c_idx_q[NEUR_W-1:0]],
                                            40'(prod_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_clr) begin
      sum_q <= '0;
    end else if (c_vld_q && state_q == S_DOT) begin
      sum_q <= sat_add(sum_q, 40'(prod_q));
    end
  end

  // bias add and table index
  always_comb begin
    act_src = (layer_q == LAYER_H1) ? acc_q[i_q] : sum_q;
    z       = sat_add(act_src, {{8{b_rd_q[15]}}, b_rd_q, 16'b0});
    sh      = {z[39], z} + 41'sh0_4000_0000;
    if (sh[40]) idx_d = '0;
    else if (sh[39:31] != '0) idx_d = 10'd1023;
    else idx_d = sh[30:21];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_ACT && step_q == 2'd1) begin
      idx_q <= idx_d;
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    layer_d  = layer_q;
    i_d      = i_q;
    cnt_d    = cnt_q;
    step_d   = step_q;
    px_d     = px_q;
    base_d   = base_q;
    last_d   = last_q;
    q_pop_o  = 1'b0;
    acc_clr  = 1'b0;
    sum_clr  = 1'b0;
    h_wen    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_req_i.op == OP_PIXEL) begin
            px_d    = q_req_i.data;
            base_d  = q_req_i.addr;
            last_d  = q_req_i.last;
            cnt_d   = '0;
            layer_d = LAYER_H1;
            i_d     = '0;
            step_d  = '0;
            state_d = q_req_i.mac ? S_MAC : S_ACT;
          end
        end
      end
      S_MAC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == n_lim + CNT_W'(2)) begin
          cnt_d   = '0;
          state_d = last_q ? S_ACT : S_IDLE;
        end
      end
      S_DOT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == n_lim + CNT_W'(2)) begin
          cnt_d   = '0;
          step_d  = '0;
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        if (step_q != 2'd3) begin
          step_d = step_q + 1'b1;
        end else begin
          step_d  = '0;
          sum_clr = 1'b1;
          cnt_d   = '0;
          case (layer_q)
            LAYER_H1: begin
              h_wen = 1'b1;
              if (i_q == NEUR_W'(HIDDEN1 - 1)) begin
                acc_clr = 1'b1;
                layer_d = LAYER_H2;
                i_d     = '0;
                state_d = S_DOT;
              end else begin
                i_d = i_q + 1'b1;
              end
            end
            LAYER_H2: begin
              h_wen   = 1'b1;
              state_d = S_DOT;
              if (i_q == NEUR_W'(HIDDEN2 - 1)) begin
                layer_d = LAYER_OUT;
                i_d     = '0;
              end else begin
                i_d = i_q + 1'b1;
              end
            end
            default: begin
              if (!out_vld_q || out_ready_i) begin
                out_load = 1'b1;
                if (i_q == NEUR_W'(OUT_SIZE - 1)) begin
                  state_d = S_IDLE;
                end else begin
                  i_d     = i_q + 1'b1;
                  state_d = S_DOT;
                end
              end else begin
                step_d  = step_q;
                sum_clr = 1'b0;
              end
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      layer_q <= LAYER_H1;
      i_q     <= '0;
      cnt_q   <= '0;
      step_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      layer_q <= layer_d;
      i_q     <= i_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    base_q <= base_d;
  end

  // output register
  assign out_vld_d = out_load | (out_vld_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_neur_q <= 4'(i_q);
      out_act_q  <= rom_q;
      out_last_q <= (i_q == NEUR_W'(OUT_SIZE - 1));
    end
  end

  assign out_valid_o      = out_vld_q;
  assign neuron_o         = out_neur_q;
  assign activation_out_o = out_act_q;
  assign last_out_o       = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/core/mlp_sigmoid_inference.sv =====
// Load items are popped and stored in the back part. A pixel inside the image
// is popped, then makes 16 passes of the shared MAC plus pipeline drain.
// A last pixel then activates each layer-one neuron, then runs a dot product
// and activation per neuron in later layers; outputs exit via a 1-deep register.
// Reset clears acc_q, pixel position and control; stores stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module mlp_sigmoid_inference
  import mlps_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [12:0] index_i,
  input  wire logic [15:0] value_i,
  input  wire logic [7:0]  pixel_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       neuron_o,
  output logic [15:0]      activation_out_o,
  output logic             last_out_o
);

  mlps_req_t push_req, pop_req;
  logic      push, full, pop, empty;

  mlps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .index_i    (index_i),
    .value_i    (value_i),
    .pixel_i    (pixel_i),
    .last_i     (last_i),
    .q_full_i   (full),
    .push_o     (push),
    .req_o      (push_req)
  );

  mlps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_req),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_req)
  );

  mlps_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (empty),
    .q_req_i          (pop_req),
    .q_pop_o          (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .neuron_o         (neuron_o),
    .activation_out_o (activation_out_o),
    .last_out_o       (last_out_o)
  );

endmodule
`default_nettype wire
